@@ hdl/afsc_pkg.sv @@
// Package: shared types, codes and decode helpers for the accelerometer step counter.
package afsc_pkg;

    localparam int WORD_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 28;
    localparam int MAG_W    = 32;
    localparam int COUNT_W  = 32;
    localparam int SQ_W     = 31;

    localparam logic [THR_W-1:0] HIGH_THR_RESET = THR_W'(2200000);
    localparam logic [THR_W-1:0] LOW_THR_RESET  = THR_W'(900000);

    typedef enum logic [0:0] {
        REG_HIGH_THR = 1'b0,
        REG_LOW_THR  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        TAG_X    = 2'd0,
        TAG_Y    = 2'd1,
        TAG_Z    = 2'd2,
        TAG_TEMP = 2'd3
    } axis_tag_t;

    typedef enum logic [1:0] {
        PH_SEEK_X = 2'd0,
        PH_SEEK_Y = 2'd1,
        PH_SEEK_Z = 2'd2
    } phase_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
        logic                       order_error;
    } triple_t;

    // bits 13:0 kept, bits 15:14 replaced by bit 12
    function automatic logic signed [SAMPLE_W-1:0] decode_word(input logic [WORD_W-1:0] w);
        return $signed({w[12], w[12], w[13:0]});
    endfunction

    function automatic axis_tag_t word_tag(input logic [WORD_W-1:0] w);
        return axis_tag_t'(w[15:14]);
    endfunction

endpackage

@@ hdl/afsc_if.sv @@
// Interfaces: sample input, result output and configuration write channels.
interface afsc_in_if
    import afsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] fifo_word;

    modport source (output valid, output fifo_word, input ready);
    modport sink   (input valid, input fifo_word, output ready);
endinterface

interface afsc_out_if
    import afsc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic signed [SAMPLE_W-1:0] z_sample;
    logic [MAG_W-1:0]           magnitude_sq;
    logic                       step_seen;
    logic [COUNT_W-1:0]         step_total;
    logic                       order_error;

    modport source (output valid, output x_sample, output y_sample, output z_sample,
                    output magnitude_sq, output step_seen, output step_total,
                    output order_error, input ready);
    modport sink   (input valid, input x_sample, input y_sample, input z_sample,
                    input magnitude_sq, input step_seen, input step_total,
                    input order_error, output ready);
endinterface

interface afsc_cfg_if
    import afsc_pkg::*;
;
    logic             valid;
    logic             ready;
    cfg_index_t       index;
    logic [THR_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/afsc_front.sv @@
// Front end: filters empty words, tracks axis order and emits triples or order breaks.
module afsc_front
    import afsc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    afsc_in_if.sink         samples,
    input  logic            push_ready,
    output logic            push_valid,
    output triple_t         push_item
);

    phase_t                     phase_reg, phase_next;
    logic signed [SAMPLE_W-1:0] held_x_reg, held_x_next;
    logic signed [SAMPLE_W-1:0] held_y_reg, held_y_next;
    logic signed [SAMPLE_W-1:0] value;
    axis_tag_t                  tag;
    logic                       take;

    assign samples.ready = push_ready;
    assign value = decode_word(samples.fifo_word);
    assign tag   = word_tag(samples.fifo_word);
    assign take  = samples.valid && push_ready && (samples.fifo_word != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK_X;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_x_reg <= held_x_next;
        held_y_reg <= held_y_next;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        push_valid  = 1'b0;
        push_item   = '0;
        if (take)
        begin
            unique case (phase_reg)
                PH_SEEK_Y:
                begin
                    if (tag == TAG_Y)
                    begin
                        held_y_next = value;
                        phase_next  = PH_SEEK_Z;
                    end
                    else
                    begin
                        push_valid            = 1'b1;
                        push_item.order_error = 1'b1;
                        phase_next            = PH_SEEK_X;
                    end
                end
                PH_SEEK_Z:
                begin
                    push_valid = 1'b1;
                    phase_next = PH_SEEK_X;
                    if (tag == TAG_Z)
                    begin
                        push_item.x = held_x_reg;
                        push_item.y = held_y_reg;
                        push_item.z = value;
                    end
                    else
                    begin
                        push_item.order_error = 1'b1;
                    end
                end
                default:
                begin
                    if (tag == TAG_X)
                    begin
                        held_x_next = value;
                        phase_next  = PH_SEEK_Y;
                    end
                end
            endcase
        end
    end

endmodule

@@ hdl/afsc_queue.sv @@
// Two-entry queue decoupling the front end from the magnitude back end.
module afsc_queue
    import afsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  triple_t push_item,
    output logic    pop_valid,
    input  logic    pop_ready,
    output triple_t pop_item
);

    triple_t     mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/afsc_back.sv @@
// Back end: squares, sum, hysteresis step detection and the output register.
module afsc_back
    import afsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  triple_t          pop_item,
    input  logic [THR_W-1:0] high_thr,
    input  logic [THR_W-1:0] low_thr,
    afsc_out_if.source       results
);

    // stage 1: squares
    logic                       s1_valid_reg;
    triple_t                    s1_item_reg;
    logic [SQ_W-1:0]            sq_x_reg, sq_y_reg, sq_z_reg;
    logic signed [MAG_W-1:0]    ext_x, ext_y, ext_z;
    logic signed [MAG_W-1:0]    prod_x, prod_y, prod_z;
    logic                       s1_ready;

    // stage 2: sum, compare, result
    logic                       out_valid_reg;
    logic                       s2_ready;
    logic [MAG_W-1:0]           sum;
    logic                       above_reg, above_next;
    logic [COUNT_W-1:0]         steps_reg, steps_next;
    logic                       step;
    logic signed [SAMPLE_W-1:0] x_reg, y_reg, z_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       step_seen_reg;
    logic [COUNT_W-1:0]         total_reg;
    logic                       err_reg;

    assign s2_ready  = !out_valid_reg || results.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop_ready = s1_ready;

    assign ext_x  = MAG_W'(pop_item.x);
    assign ext_y  = MAG_W'(pop_item.y);
    assign ext_z  = MAG_W'(pop_item.z);
    assign prod_x = ext_x * ext_x;
    assign prod_y = ext_y * ext_y;
    assign prod_z = ext_z * ext_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pop_valid)
        begin
            s1_item_reg <= pop_item;
            sq_x_reg    <= prod_x[SQ_W-1:0];
            sq_y_reg    <= prod_y[SQ_W-1:0];
            sq_z_reg    <= prod_z[SQ_W-1:0];
        end
    end

    assign sum = MAG_W'(sq_x_reg) + MAG_W'(sq_y_reg) + MAG_W'(sq_z_reg);

    always_comb
    begin
        above_next = above_reg;
        steps_next = steps_reg;
        step       = 1'b0;
        if (!s1_item_reg.order_error)
        begin
            priority if ((sum > MAG_W'(high_thr)) && !above_reg)
            begin
                above_next = 1'b1;
                step       = 1'b1;
                steps_next = steps_reg + COUNT_W'(1);
            end
            else if ((sum < MAG_W'(low_thr)) && above_reg)
            begin
                above_next = 1'b0;
            end
            else
            begin
                above_next = above_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            above_reg     <= 1'b0;
            steps_reg     <= '0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                above_reg <= above_next;
                steps_reg <= steps_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            x_reg         <= s1_item_reg.x;
            y_reg         <= s1_item_reg.y;
            z_reg         <= s1_item_reg.z;
            mag_reg       <= s1_item_reg.order_error ? '0 : sum;
            step_seen_reg <= step;
            total_reg     <= s1_item_reg.order_error ? '0 : steps_next;
            err_reg       <= s1_item_reg.order_error;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.x_sample     = x_reg;
    assign results.y_sample     = y_reg;
    assign results.z_sample     = z_reg;
    assign results.magnitude_sq = mag_reg;
    assign results.step_seen    = step_seen_reg;
    assign results.step_total   = total_reg;
    assign results.order_error  = err_reg;

endmodule

@@ hdl/accel_fifo_step_counter.sv @@
// Top level: accelerometer FIFO word step counter with threshold hysteresis.
//
// Channels: "samples" takes one raw 16-bit FIFO word per transfer; zero words
// and non-x words while x is sought are absorbed. "results" gives one item
// per completed triple (samples, sum of squares, step flag, running count) or
// per axis order break (order_error set, other fields zero). "cfg" writes the
// high (index 0) and low (index 1) thresholds; it is always ready, and the user
// must write it only while the block is idle; the block does not enforce this.
// Throughput: one word per clock while samples.ready is high. A triple's
// result passes through the queue, the square stage and the sum and compare
// stage after the transfer of its z word.
// A stalled receiver holds the output register; the two-entry queue and the
// square stage keep absorbing words until they fill, then samples.ready drops.
// Reset: phase returns to seeking x, the detector is disarmed, the step count
// clears, thresholds return to 2200000 and 900000, all pipes empty.
module accel_fifo_step_counter
    import afsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    afsc_in_if.sink    samples,
    afsc_out_if.source results,
    afsc_cfg_if.sink   cfg
);

    logic [THR_W-1:0] high_thr_reg;
    logic [THR_W-1:0] low_thr_reg;
    logic             push_valid, push_ready;
    triple_t          push_item;
    logic             pop_valid, pop_ready;
    triple_t          pop_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= HIGH_THR_RESET;
            low_thr_reg  <= LOW_THR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_HIGH_THR: high_thr_reg <= cfg.data;
                REG_LOW_THR:  low_thr_reg  <= cfg.data;
                default:      high_thr_reg <= high_thr_reg;
            endcase
        end
    end

    afsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    afsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    afsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .high_thr  (high_thr_reg),
        .low_thr   (low_thr_reg),
        .results   (results)
    );

endmodule
